/* hw/rtl/uart_motor_command_decoder_assert.svh */
// Assertion helpers for the motor command decoder. They sample on clock and
// stay quiet while reset is high.
`ifndef UART_MOTOR_COMMAND_DECODER_ASSERT_SVH
`define UART_MOTOR_COMMAND_DECODER_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define UMCD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define UMCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Check that a condition never holds.
`define UMCD_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

/* hw/rtl/umcd_pkg.sv */
package umcd_pkg;

   // Default sizes
   localparam int FIELD_CHARS_DEF     = 4;
   localparam int IDLE_COUNT_BITS_DEF = 20;

   // Timeout register
   localparam int              CFG_BITS       = 20;
   localparam logic [CFG_BITS-1:0] AUTO_OFF_RESET = 20'd2500;

   // Magnitude saturates one above the largest duty value
   localparam int             MAG_BITS = 9;
   localparam logic [MAG_BITS-1:0] MAG_CAP  = 9'd256;
   localparam logic [7:0]     SPEED_MAX = 8'd255;

   // Characters of the command set
   localparam logic [7:0] CH_LEFT   = 8'h4C;
   localparam logic [7:0] CH_RIGHT  = 8'h52;
   localparam logic [7:0] CH_HORN   = 8'h48;
   localparam logic [7:0] CH_FLASH  = 8'h46;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   // Parsed value of one decimal field
   typedef struct packed {
      logic                neg;
      logic [MAG_BITS-1:0] mag;
   } field_value_type;

   // Drive of one motor
   typedef struct packed {
      logic [7:0] speed;
      logic       reverse;
   } motor_drive_type;

   // Map a signed field value to duty and direction
   function automatic motor_drive_type drive_of(input field_value_type f);
      logic [7:0]      m;
      motor_drive_type d;
      m = (f.mag > MAG_BITS'(SPEED_MAX)) ? SPEED_MAX : f.mag[7:0];
      if (m == 8'd0) begin
         d.speed   = 8'd0;
         d.reverse = 1'b0;
      end else if (f.neg) begin
         d.speed   = SPEED_MAX - m;
         d.reverse = 1'b1;
      end else begin
         d.speed   = m;
         d.reverse = 1'b0;
      end
      return d;
   endfunction

endpackage

/* hw/rtl/umcd_num_field.sv */
module umcd_num_field #(
   parameter int LIMIT = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       feed,
   input  logic [7:0]                 rx_byte,
   output umcd_pkg::field_value_type  value
);
   import umcd_pkg::*;

   localparam int CNT_BITS = $clog2(LIMIT + 1);
   localparam int ACC_BITS = MAG_BITS + 3;

   localparam logic [1:0] PH_SKIP = 2'd0;
   localparam logic [1:0] PH_NUM  = 2'd1;
   localparam logic [1:0] PH_STOP = 2'd2;

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [1:0]          phase_ff, phase_in;
   logic                neg_ff, neg_in;
   logic [MAG_BITS-1:0] mag_ff, mag_in;

   logic                is_digit;
   logic                is_blank;
   logic                is_sign;
   logic [ACC_BITS-1:0] acc;
   logic [MAG_BITS-1:0] acc_sat;

   // Classify the word and build mag * 10 + digit
   always_comb begin
      is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
      is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_LF) || (rx_byte == CH_VT) ||
                 (rx_byte == CH_FF) || (rx_byte == CH_TAB) || (rx_byte == CH_CR);
      is_sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
      acc      = {mag_ff, 3'b000} + {2'b00, mag_ff, 1'b0} + {{(ACC_BITS-4){1'b0}}, rx_byte[3:0]};
      acc_sat  = (acc > ACC_BITS'(MAG_CAP)) ? MAG_CAP : acc[MAG_BITS-1:0];
   end

   // Advance the atoi-style parse by one character
   always_comb begin
      count_in = count_ff;
      phase_in = phase_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      if (clear) begin
         count_in = '0;
         phase_in = PH_SKIP;
         neg_in   = 1'b0;
         mag_in   = '0;
      end else if (feed && (count_ff < CNT_BITS'(LIMIT))) begin
         count_in = count_ff + CNT_BITS'(1);
         case (phase_ff)
            PH_SKIP: begin
               if (is_blank) begin
                  phase_in = PH_SKIP;
               end else if (is_sign) begin
                  neg_in   = (rx_byte == CH_MINUS);
                  phase_in = PH_NUM;
               end else if (!is_digit) begin
                  phase_in = PH_STOP;
               end else begin
                  phase_in = PH_NUM;
                  mag_in   = acc_sat;
               end
            end
            PH_NUM: begin
               if (!is_digit) begin
                  phase_in = PH_STOP;
               end else begin
                  mag_in = acc_sat;
               end
            end
            default: begin
               phase_in = PH_STOP;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         phase_ff <= PH_SKIP;
         neg_ff   <= 1'b0;
         mag_ff   <= '0;
      end else begin
         count_ff <= count_in;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         mag_ff   <= mag_in;
      end
   end

   assign value.neg = neg_ff;
   assign value.mag = mag_ff;

endmodule

/* hw/rtl/uart_motor_command_decoder.sv */
// Serial drive-command decoder for a two-motor robot. Each input word is either a
// received UART byte or a one-millisecond tick, and each gives exactly one result
// word with the current left/right PWM duty and direction, the horn, and a
// timeout flag. 'L', 'R' and 'H' start a new decimal field (up to FIELD_CHARS
// characters for the motors and one for the horn, sign and blanks included); a
// carriage return applies the fields, and following non-command bytes apply them
// again. After csr auto_off_ms idle ticks since the last byte, all drive is forced
// to zero until the next apply. rsp_valid rises once the req word has passed the
// input register and then the result register; one word is accepted every cycle
// while the result register is empty or rsp_ready is high, as the parse and idle
// state update with each word. Write the csr only while no word is in flight.
module uart_motor_command_decoder #(
   parameter int FIELD_CHARS     = umcd_pkg::FIELD_CHARS_DEF,
   parameter int IDLE_COUNT_BITS = umcd_pkg::IDLE_COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [umcd_pkg::CFG_BITS-1:0] csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_left_speed,
   output logic                          rsp_left_reverse,
   output logic [7:0]                    rsp_right_speed,
   output logic                          rsp_right_reverse,
   output logic                          rsp_horn_on,
   output logic                          rsp_timed_out
);
   import umcd_pkg::*;

   `include "uart_motor_command_decoder_assert.svh"

   localparam int CMP_BITS = (IDLE_COUNT_BITS > CFG_BITS) ? IDLE_COUNT_BITS : CFG_BITS;

   localparam logic [2:0] MODE_NONE  = 3'd0;
   localparam logic [2:0] MODE_LEFT  = 3'd1;
   localparam logic [2:0] MODE_RIGHT = 3'd2;
   localparam logic [2:0] MODE_HORN  = 3'd3;
   localparam logic [2:0] MODE_FLASH = 3'd4;
   localparam logic [2:0] MODE_END   = 3'd5;
   localparam logic [2:0] MODE_TAB   = 3'd6;

   typedef struct packed {
      motor_drive_type left;
      motor_drive_type right;
      logic            horn;
   } drive_type;

   logic [CFG_BITS-1:0]        auto_off_ff;
   logic                       in_vld_ff, in_vld_in;
   logic                       in_cmd_ff;
   logic [7:0]                 in_byte_ff;
   logic [2:0]                 mode_ff, mode_in;
   logic [IDLE_COUNT_BITS-1:0] idle_ff, idle_in;
   drive_type                  drive_ff, drive_in;
   logic                       rsp_vld_ff, rsp_vld_in;
   drive_type                  rsp_drive_ff;
   logic                       rsp_to_ff;

   logic            advance;
   logic            step;
   logic            is_byte;
   logic            forced;
   logic            apply;
   logic            feed_left, feed_right, feed_horn;
   logic            clear_left, clear_right, clear_horn;
   field_value_type left_val, right_val, horn_val;
   drive_type       applied;
   logic            rsp_quiet;
   logic            rev_full;

   // Handshake: result register frees the input register
   assign advance   = !rsp_vld_ff || rsp_ready;
   assign step      = in_vld_ff && advance;
   assign req_ready = !in_vld_ff || advance;
   assign in_vld_in = req_ready ? req_valid : in_vld_ff;
   assign rsp_vld_in = advance ? in_vld_ff : rsp_vld_ff;

   // Decode the command letters
   assign is_byte = step && !in_cmd_ff;
   always_comb begin
      mode_in = mode_ff;
      if (is_byte) begin
         case (in_byte_ff)
            CH_LEFT:  mode_in = MODE_LEFT;
            CH_RIGHT: mode_in = MODE_RIGHT;
            CH_HORN:  mode_in = MODE_HORN;
            CH_FLASH: mode_in = MODE_FLASH;
            CH_CR:    mode_in = MODE_END;
            CH_TAB:   mode_in = MODE_TAB;
            default:  mode_in = mode_ff;
         endcase
      end
   end

   assign clear_left  = is_byte && (in_byte_ff == CH_LEFT);
   assign clear_right = is_byte && (in_byte_ff == CH_RIGHT);
   assign clear_horn  = is_byte && (in_byte_ff == CH_HORN);
   assign feed_left   = is_byte && (mode_in == MODE_LEFT) && (in_byte_ff != CH_LEFT);
   assign feed_right  = is_byte && (mode_in == MODE_RIGHT) && (in_byte_ff != CH_RIGHT);
   assign feed_horn   = is_byte && (mode_in == MODE_HORN) && (in_byte_ff != CH_HORN);
   assign apply       = is_byte && (mode_in == MODE_END);

   umcd_num_field #(.LIMIT(FIELD_CHARS)) u_left (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear_left),
      .feed    (feed_left),
      .rx_byte (in_byte_ff),
      .value   (left_val)
   );

   umcd_num_field #(.LIMIT(FIELD_CHARS)) u_right (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear_right),
      .feed    (feed_right),
      .rx_byte (in_byte_ff),
      .value   (right_val)
   );

   umcd_num_field #(.LIMIT(1)) u_horn (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear_horn),
      .feed    (feed_horn),
      .rx_byte (in_byte_ff),
      .value   (horn_val)
   );

   // Clear idle count on a byte, saturate on ticks
   always_comb begin
      idle_in = idle_ff;
      if (step) begin
         if (!in_cmd_ff) begin
            idle_in = '0;
         end else if (idle_ff != {IDLE_COUNT_BITS{1'b1}}) begin
            idle_in = idle_ff + IDLE_COUNT_BITS'(1);
         end
      end
   end

   assign forced = CMP_BITS'(idle_in) >= CMP_BITS'(auto_off_ff);

   // Apply fields, then force off on timeout
   always_comb begin
      applied.left  = drive_of(left_val);
      applied.right = drive_of(right_val);
      applied.horn  = (horn_val.mag != '0);
      drive_in = drive_ff;
      if (step) begin
         if (forced) begin
            drive_in = '0;
         end else if (apply) begin
            drive_in = applied;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_off_ff <= AUTO_OFF_RESET;
         in_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         mode_ff     <= MODE_NONE;
         idle_ff     <= '0;
         drive_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            auto_off_ff <= csr_wr_data;
         end
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         mode_ff    <= mode_in;
         idle_ff    <= idle_in;
         drive_ff   <= drive_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff  <= req_command;
         in_byte_ff <= req_rx_byte;
      end
      if (step) begin
         rsp_drive_ff <= drive_in;
         rsp_to_ff    <= forced;
      end
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_left_speed    = rsp_drive_ff.left.speed;
   assign rsp_left_reverse  = rsp_drive_ff.left.reverse;
   assign rsp_right_speed   = rsp_drive_ff.right.speed;
   assign rsp_right_reverse = rsp_drive_ff.right.reverse;
   assign rsp_horn_on       = rsp_drive_ff.horn;
   assign rsp_timed_out     = rsp_to_ff;

   // Conditions watched by the checks below
   assign rsp_quiet = (rsp_left_speed == 8'd0) && (rsp_right_speed == 8'd0) && !rsp_horn_on;
   assign rev_full  = (drive_ff.left.reverse && (drive_ff.left.speed == SPEED_MAX)) ||
                      (drive_ff.right.reverse && (drive_ff.right.speed == SPEED_MAX));

   // Timeout result carries no drive
   `UMCD_ASSERT_SAME(a_timeout_quiet, rsp_valid && rsp_timed_out, rsp_quiet, "drive after timeout")
   // Received byte restarts the idle count
   `UMCD_ASSERT_NEXT(a_idle_cleared, step && !in_cmd_ff, idle_ff == '0, "idle not cleared")
   // Reverse drive never reaches full duty
   `UMCD_ASSERT_NEVER(a_reverse_duty, rev_full, "reverse drive at full duty")

endmodule
